>>> rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;
    localparam int MEM_BYTES_DEF = 4096;
    localparam int MAX_SEGS_DEF  = 16;
    localparam int HDR_BYTES     = 24;
    localparam int CFG_W         = 13;
    localparam int SIZE_W        = 13;
    localparam int OFF_W         = 12;
    localparam int STAT_W        = 2;
    localparam int REGION_RESET  = 256;

    localparam logic [STAT_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_RESOLVE,
        OP_SHIFT_DOWN,
        OP_SHIFT_UP,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
    } sts_t;
endpackage

>>> rtl/core/ffa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_datapath
// Free-segment table, scan index, and segment arithmetic.
// ----------------------------------------------------------------------------
module ffa_datapath #(
    parameter int MEM_BYTES = ffa_pkg::MEM_BYTES_DEF,
    parameter int MAX_SEGS  = ffa_pkg::MAX_SEGS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ffa_pkg::cmd_t               cmd,
    output ffa_pkg::sts_t               sts,
    input  logic                        cfg_wr_en,
    input  logic [ffa_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        req_type,
    input  logic [ffa_pkg::SIZE_W-1:0]  req_size,
    input  logic [ffa_pkg::OFF_W-1:0]   block_offset,
    input  logic [ffa_pkg::SIZE_W-1:0]  free_size,
    output logic [ffa_pkg::STAT_W-1:0]  status,
    output logic [ffa_pkg::OFF_W-1:0]   granted_offset,
    output logic [ffa_pkg::SIZE_W-1:0]  granted_size
);
    import ffa_pkg::*;

    localparam int IDX_W = (MAX_SEGS > 2) ? $clog2(MAX_SEGS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGS + 1);
    localparam int W     = SIZE_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGS);
    localparam logic [W-1:0] HDR_W = W'(HDR_BYTES);

    logic [OFF_W-1:0]  st_reg  [MAX_SEGS];
    logic [SIZE_W-1:0] len_reg [MAX_SEGS];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CFG_W-1:0]  region_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              type_reg;
    logic [W-1:0]      need_reg;
    logic [W-1:0]      off_reg;
    logic [W-1:0]      sz_reg;
    logic              found_reg;
    logic              drop_reg;
    logic [W-1:0]      prev_end_reg;
    logic [W-1:0]      merged_reg;
    logic [CNT_W-1:0]  stop_reg;
    logic [OFF_W-1:0]  wst_reg;
    logic [SIZE_W-1:0] wlen_reg;
    logic              wen_reg;
    logic [STAT_W-1:0] status_reg;
    logic [OFF_W-1:0]  goff_reg;
    logic [SIZE_W-1:0] gsize_reg;

    logic [IDX_W-1:0] idx;
    logic [W-1:0]     cur_st, cur_len;
    logic             in_range;
    logic [CFG_W-1:0] clamp;

    assign idx      = idx_reg[IDX_W-1:0];
    assign in_range = idx_reg < cnt_reg;
    assign cur_st   = W'(st_reg[idx]);
    assign cur_len  = W'(len_reg[idx]);

    always_comb begin
        clamp = cfg_wr_data;
        if (cfg_wr_data < CFG_W'(HDR_BYTES)) clamp = CFG_W'(HDR_BYTES);
        if (cfg_wr_data > CFG_W'(MEM_BYTES)) clamp = CFG_W'(MEM_BYTES);
    end

    always_comb begin
        sts.scan_done = 1'b0;
        if (type_reg == REQ_ALLOC) begin
            sts.scan_done = !in_range || (cur_len >= need_reg);
        end else begin
            sts.scan_done = !in_range || (cur_st >= off_reg);
        end
        sts.shift_done = (cmd.op == OP_SHIFT_DOWN) ? (idx_reg + 1'b1 >= stop_reg)
                                                   : (idx_reg <= stop_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= CNT_W'(1);
            region_reg <= CFG_W'(REGION_RESET);
            st_reg[0]  <= '0;
            len_reg[0] <= SIZE_W'(REGION_RESET);
            idx_reg    <= '0;
        end else if (cfg_wr_en) begin
            region_reg <= clamp;
            cnt_reg    <= CNT_W'(1);
            st_reg[0]  <= '0;
            len_reg[0] <= SIZE_W'(clamp);
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    type_reg  <= req_type;
                    need_reg  <= (W'(req_size) + HDR_W + W'(3)) & ~W'(3);
                    off_reg   <= W'(block_offset);
                    sz_reg    <= W'(free_size);
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    drop_reg  <= 1'b0;
                    prev_end_reg <= '1;
                    wen_reg   <= 1'b0;
                    goff_reg  <= '0;
                    gsize_reg <= '0;
                end
                OP_SCAN: begin
                    if (!sts.scan_done) begin
                        prev_end_reg <= cur_st + cur_len;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                OP_RESOLVE: begin
                    wen_reg <= 1'b0;
                    stop_reg <= idx_reg;
                    if (type_reg == REQ_ALLOC) begin
                        if (!in_range) begin
                            status_reg <= ST_NOFIT;
                        end else begin
                            status_reg <= ST_GRANT;
                            goff_reg   <= OFF_W'(cur_st);
                            gsize_reg  <= SIZE_W'(need_reg);
                            if (cur_len - need_reg >= HDR_W) begin
                                wen_reg  <= 1'b1;
                                wst_reg  <= OFF_W'(cur_st + need_reg);
                                wlen_reg <= SIZE_W'(cur_len - need_reg);
                            end else begin
                                stop_reg <= cnt_reg;
                                drop_reg <= 1'b1;
                            end
                        end
                    end else begin
                        status_reg <= ST_FREED;
                        if (sz_reg != '0 && off_reg + sz_reg <= W'(region_reg)) begin
                            if (prev_end_reg == off_reg && in_range
                                && off_reg + sz_reg == cur_st) begin
                                idx_reg  <= idx_reg - 1'b1;
                                merged_reg <= cur_len;
                                stop_reg <= cnt_reg;
                                found_reg <= 1'b1;
                                drop_reg <= 1'b1;
                            end else if (prev_end_reg == off_reg) begin
                                idx_reg  <= idx_reg - 1'b1;
                                wen_reg  <= 1'b1;
                                wst_reg  <= st_reg[IDX_W'(idx_reg - 1'b1)];
                                wlen_reg <= SIZE_W'(W'(len_reg[IDX_W'(idx_reg - 1'b1)])
                                                    + sz_reg);
                            end else if (in_range && off_reg + sz_reg == cur_st) begin
                                wen_reg  <= 1'b1;
                                wst_reg  <= OFF_W'(off_reg);
                                wlen_reg <= SIZE_W'(cur_len + sz_reg);
                            end else if (cnt_reg >= MAX_CNT) begin
                                status_reg <= ST_FULL;
                            end else begin
                                wen_reg  <= 1'b1;
                                wst_reg  <= OFF_W'(off_reg);
                                wlen_reg <= SIZE_W'(sz_reg);
                                stop_reg <= idx_reg;
                                idx_reg  <= cnt_reg;
                                cnt_reg  <= cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                OP_SHIFT_DOWN: begin
                    if (found_reg) begin
                        len_reg[idx] <= SIZE_W'(cur_len + sz_reg + merged_reg);
                        found_reg <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end else if (idx_reg + 1'b1 < stop_reg) begin
                        st_reg[idx]  <= st_reg[IDX_W'(idx_reg + 1'b1)];
                        len_reg[idx] <= len_reg[IDX_W'(idx_reg + 1'b1)];
                        idx_reg <= idx_reg + 1'b1;
                    end else if (drop_reg) begin
                        cnt_reg  <= cnt_reg - 1'b1;
                        drop_reg <= 1'b0;
                    end
                end
                OP_SHIFT_UP: begin
                    if (idx_reg > stop_reg) begin
                        st_reg[idx]  <= st_reg[IDX_W'(idx_reg - 1'b1)];
                        len_reg[idx] <= len_reg[IDX_W'(idx_reg - 1'b1)];
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (wen_reg) begin
                        st_reg[idx]  <= wst_reg;
                        len_reg[idx] <= wlen_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign status         = status_reg;
    assign granted_offset = goff_reg;
    assign granted_size   = gsize_reg;
endmodule

>>> rtl/core/ffa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: load, scan, resolve, shift, write, deliver.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t cmd
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_RES, S_DOWN, S_UP, S_WR, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op = OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (sts.scan_done) state_next = S_RES;
            end
            S_RES: begin
                cmd.op = OP_RESOLVE;
                state_next = S_DOWN;
            end
            S_DOWN: begin
                cmd.op = OP_SHIFT_DOWN;
                if (sts.shift_done) state_next = S_UP;
            end
            S_UP: begin
                cmd.op = OP_SHIFT_UP;
                if (sts.shift_done) state_next = S_WR;
            end
            S_WR: begin
                cmd.op = OP_WRITE;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_load_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_SCAN)) else $error("load not followed by scan");
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !m_valid_reg) |=> (m_valid && state_reg == S_IDLE))
        else $error("result not posted");
`endif
endmodule

>>> rtl/core/first_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_core
// First-fit allocator with coalescing over a byte region.
// ----------------------------------------------------------------------------
// Input channel s_*: one allocate or free request per transaction.
// Output channel m_*: one result per request (status, offset, size).
// A request walks the table one entry per cycle: a scan up to the first
// fitting segment or the insert point, a resolve step, a shift pass over
// the entries behind it, a write step and an output step. Scan and shift
// together cover the table once; the table is a register file walked by
// one index. One request is in flight at a time; the result register
// holds while the receiver stalls, and the next request is accepted no
// earlier than the cycle in which the result is taken.
// Reset: region 256 bytes, one free segment. Writing cfg_wr_data with
// cfg_wr_en rebuilds the table as one segment; write only when idle.
// ----------------------------------------------------------------------------
module first_fit_allocator_core #(
    parameter int MEM_BYTES = ffa_pkg::MEM_BYTES_DEF,
    parameter int MAX_SEGS  = ffa_pkg::MAX_SEGS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ffa_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [ffa_pkg::SIZE_W-1:0]  s_req_size,
    input  logic [ffa_pkg::OFF_W-1:0]   s_block_offset,
    input  logic [ffa_pkg::SIZE_W-1:0]  s_free_size,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ffa_pkg::STAT_W-1:0]  m_status,
    output logic [ffa_pkg::OFF_W-1:0]   m_granted_offset,
    output logic [ffa_pkg::SIZE_W-1:0]  m_granted_size
);
    import ffa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    ffa_datapath #(.MEM_BYTES(MEM_BYTES), .MAX_SEGS(MAX_SEGS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .req_type(s_req_type), .req_size(s_req_size),
        .block_offset(s_block_offset), .free_size(s_free_size),
        .status(m_status), .granted_offset(m_granted_offset),
        .granted_size(m_granted_size)
    );
endmodule

>>> test/first_fit_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_core_tb
// Self-checking bench for the first-fit allocator core. A behavioral copy of
// the free-segment table predicts status, offset and size of every request;
// a queue-fed driver and a monitor run with random gaps and stalls, across
// several region sizes, including a long output stall that backs up input.
// ----------------------------------------------------------------------------
module first_fit_allocator_core_tb;
    import ffa_pkg::*;

    localparam int NSEG      = MAX_SEGS_DEF;
    localparam int IDLE_LIM  = 20000;

    typedef struct {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [OFF_W-1:0]  block_offset;
        logic [SIZE_W-1:0] free_size;
    } req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  goff;
        logic [SIZE_W-1:0] gsize;
    } rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [SIZE_W-1:0] s_req_size = '0;
    logic [OFF_W-1:0] s_block_offset = '0;
    logic [SIZE_W-1:0] s_free_size = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [OFF_W-1:0] m_granted_offset;
    logic [SIZE_W-1:0] m_granted_size;

    first_fit_allocator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_req_size(s_req_size), .s_block_offset(s_block_offset),
        .s_free_size(s_free_size),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_offset(m_granted_offset), .m_granted_size(m_granted_size)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    int unsigned region;
    int unsigned seg_st[NSEG];
    int unsigned seg_ln[NSEG];
    int unsigned nseg;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int errors = 0;
    int idle_cycles = 0;
    logic hold_off = 1'b0;

    // sender's own view of outstanding grants, to build sensible frees
    int unsigned live_off[$];
    int unsigned live_sz[$];

    function automatic void add_req(req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void table_reset(int unsigned v);
        if (v < HDR_BYTES) v = HDR_BYTES;
        if (v > MEM_BYTES_DEF) v = MEM_BYTES_DEF;
        region = v;
        foreach (seg_st[k]) begin
            seg_st[k] = 0;
            seg_ln[k] = 0;
        end
        seg_ln[0] = region;
        nseg = 1;
    endfunction

    function automatic void drop_seg(int unsigned idx);
        for (int unsigned k = idx; k + 1 < nseg; k++) begin
            seg_st[k] = seg_st[k+1];
            seg_ln[k] = seg_ln[k+1];
        end
        nseg--;
        seg_st[nseg] = 0;
        seg_ln[nseg] = 0;
    endfunction

    function automatic rsp_t allocate_or_free(req_t r);
        rsp_t o;
        int unsigned need, off, sz, pos;
        bit pa, na;
        o.goff = '0;
        o.gsize = '0;
        if (r.req_type == REQ_ALLOC) begin
            need = (r.req_size + HDR_BYTES + 3) & ~32'd3;
            o.status = ST_NOFIT;
            for (int unsigned i = 0; i < nseg; i++) begin
                if (seg_ln[i] >= need) begin
                    o.goff = seg_st[i][OFF_W-1:0];
                    o.gsize = need[SIZE_W-1:0];
                    if (seg_ln[i] - need >= HDR_BYTES) begin
                        seg_st[i] += need;
                        seg_ln[i] -= need;
                    end else begin
                        drop_seg(i);
                    end
                    o.status = ST_GRANT;
                    break;
                end
            end
        end else begin
            off = r.block_offset;
            sz = r.free_size;
            o.status = ST_FREED;
            if (sz != 0 && off + sz <= region) begin
                pos = 0;
                while (pos < nseg && seg_st[pos] < off) pos++;
                pa = pos > 0 && seg_st[pos-1] + seg_ln[pos-1] == off;
                na = pos < nseg && off + sz == seg_st[pos];
                if (pa && na) begin
                    seg_ln[pos-1] += sz + seg_ln[pos];
                    drop_seg(pos);
                end else if (pa) begin
                    seg_ln[pos-1] += sz;
                end else if (na) begin
                    seg_st[pos] = off;
                    seg_ln[pos] += sz;
                end else if (nseg >= NSEG) begin
                    o.status = ST_FULL;
                end else begin
                    for (int unsigned k = nseg; k > pos; k--) begin
                        seg_st[k] = seg_st[k-1];
                        seg_ln[k] = seg_ln[k-1];
                    end
                    seg_st[pos] = off;
                    seg_ln[pos] = sz;
                    nseg++;
                end
            end
        end
        return o;
    endfunction

    function automatic req_t mk_alloc(int unsigned size);
        req_t r;
        r.req_type = REQ_ALLOC;
        r.req_size = size[SIZE_W-1:0];
        r.block_offset = OFF_W'($urandom);
        r.free_size = SIZE_W'($urandom);
        return r;
    endfunction

    function automatic req_t mk_free(int unsigned off, int unsigned size);
        req_t r;
        r.req_type = REQ_FREE;
        r.req_size = SIZE_W'($urandom);
        r.block_offset = off[OFF_W-1:0];
        r.free_size = size[SIZE_W-1:0];
        return r;
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            gap = s_gap;
            if (s_valid && s_ready) begin
                expected_rsps.insert(expected_rsps.size(),
                                     allocate_or_free(pending_reqs.pop_front()));
                gap = $urandom_range(0, 11);
            end
            if (!s_valid || s_ready) begin
                if (gap == 0 && pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_req_type <= pending_reqs[0].req_type;
                    s_req_size <= pending_reqs[0].req_size;
                    s_block_offset <= pending_reqs[0].block_offset;
                    s_free_size <= pending_reqs[0].free_size;
                end else begin
                    s_valid <= 1'b0;
                    if (gap > 0) gap = gap - 1;
                end
                s_gap <= gap;
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                idle_cycles <= 0;
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result status=%0d", m_status);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_status);
                        errors++;
                    end
                    if (m_granted_offset !== e.goff) begin
                        $error("granted_offset exp %0d got %0d", e.goff, m_granted_offset);
                        errors++;
                    end
                    if (m_granted_size !== e.gsize) begin
                        $error("granted_size exp %0d got %0d", e.gsize, m_granted_size);
                        errors++;
                    end
                end
                m_gap <= $urandom_range(0, 11) * $urandom_range(0, 1);
                m_ready <= 1'b0;
            end else if (s_valid && s_ready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (!(m_valid && m_ready)) begin
                if (hold_off) begin
                    m_ready <= 1'b0;
                end else if (m_gap > 0) begin
                    m_gap <= m_gap - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            if (idle_cycles >= IDLE_LIM) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_valid && expected_rsps.size() == 0);
        repeat (2 * NSEG + 10) @(posedge aclk);
    endtask

    task automatic set_region(int unsigned v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        table_reset(v[CFG_W-1:0]);
        live_off.delete();
        live_sz.delete();
    endtask

    // track grants on the stimulus side with a shadow predictor run
    task automatic random_phase(int n, int unsigned max_pay);
        int unsigned sh_st[NSEG], sh_ln[NSEG], sh_n, sh_reg;
        rsp_t o;
        req_t r;
        int idx;
        sh_st = seg_st; sh_ln = seg_ln; sh_n = nseg; sh_reg = region;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: r = mk_free(OFF_W'($urandom), SIZE_W'($urandom));
                1: r = mk_alloc(SIZE_W'($urandom));
                2, 3, 4, 5: r = mk_alloc($urandom_range(0, max_pay));
                default: begin
                    if (live_off.size() == 0) r = mk_alloc($urandom_range(0, max_pay));
                    else begin
                        idx = $urandom_range(0, live_off.size() - 1);
                        r = mk_free(live_off[idx], live_sz[idx]);
                        live_off.delete(idx);
                        live_sz.delete(idx);
                    end
                end
            endcase
            o = allocate_or_free(r);
            if (r.req_type == REQ_ALLOC && o.status == ST_GRANT) begin
                live_off.insert(live_off.size(), o.goff);
                live_sz.insert(live_sz.size(), o.gsize);
            end
            add_req(r);
        end
        seg_st = sh_st; seg_ln = sh_ln; nseg = sh_n; region = sh_reg;
    endtask

    initial begin
        table_reset(REGION_RESET);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // directed
        random_phase(0, 0);
        add_req(mk_alloc(0));
        add_req(mk_alloc(1));
        add_req(mk_alloc(8191));
        add_req(mk_alloc(4096));
        add_req(mk_free(0, 0));
        add_req(mk_free(4095, 4096));
        add_req(mk_free(200, 100));
        add_req(mk_free(0, 24));
        add_req(mk_free(0, 24));
        add_req(mk_free(24, 28));
        add_req(mk_alloc(180));
        add_req(mk_alloc(10));
        drain();
        set_region(24);
        add_req(mk_alloc(0));
        add_req(mk_free(0, 24));
        add_req(mk_alloc(1));
        drain();
        set_region(4096);
        for (int i = 0; i < 17; i++) add_req(mk_alloc(24));
        for (int i = 0; i < 17; i++) add_req(mk_free(i * 96, 48));
        add_req(mk_alloc(4000));
        drain();
        set_region(8191);
        random_phase(300, 600);
        drain();
        set_region(0);
        random_phase(50, 40);
        drain();
        set_region($urandom_range(24, 4096));
        random_phase(400, 300);
        // hold the receiver off while the sender keeps offering
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
        drain();
        set_region(512);
        random_phase(650, 60);
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_datapath.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_allocator_core.sv
test/first_fit_allocator_core_tb.sv
